// ===== rtl/mahp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahp_pkg
// shared types, codes and the hex digit decode for the mac address parser
// ----------------------------------------------------------------------------
package mahp_pkg;

  localparam int MAX_OCTETS = 16;
  localparam int CNT_W      = 5;  // holds 0..MAX_OCTETS and the count register
  localparam int PHASE_W    = 3;

  // parser phases
  localparam logic [PHASE_W-1:0] PH_START       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LOW         = 3'd1;
  localparam logic [PHASE_W-1:0] PH_AFTER       = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ERR_LONG    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ERR_ILLEGAL = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_LONG    = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  // configuration register indexes
  localparam logic REG_OCTET_COUNT = 1'b0;
  localparam logic REG_SEPARATOR   = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    logic [1:0] status;
    logic       last;
  } mahp_result_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    return v;
  endfunction

endpackage

// ===== rtl/mahp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahp_parser
// parse state and one-character step logic
// ----------------------------------------------------------------------------
module mahp_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [7:0]                    char_code,
  input  logic [mahp_pkg::CNT_W-1:0]    octet_count,
  input  logic [7:0]                    separator_char,
  output mahp_pkg::mahp_result_t        result
);
  import mahp_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OCTETS);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [3:0]         high_nibble, high_nibble_next;
  logic [CNT_W-1:0]   octets_done, octets_done_next;
  logic [CNT_W-1:0]   wanted;
  logic [CNT_W-1:0]   base_done;
  logic [4:0]         hv;
  logic               is_nul;
  logic               skip;
  logic               run_start;

  assign wanted = (octet_count > MAX_CNT) ? MAX_CNT : octet_count;
  assign hv     = hex_value(char_code);
  assign is_nul = (char_code == 8'h00);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    octets_done_next = octets_done;
    result           = '0;
    base_done        = octets_done;
    skip             = 1'b0;
    run_start        = 1'b0;

    case (phase)
      PH_ERR_LONG, PH_ERR_ILLEGAL: begin
        if (is_nul) begin
          result.valid     = 1'b1;
          result.last      = 1'b1;
          result.status    = (phase == PH_ERR_LONG) ? ST_LONG : ST_ILLEGAL;
          phase_next       = PH_START;
          high_nibble_next = '0;
          octets_done_next = '0;
        end
      end
      PH_LOW: begin
        if (is_nul) begin
          result.valid     = 1'b1;
          result.last      = 1'b1;
          result.status    = ST_SHORT;
          phase_next       = PH_START;
          high_nibble_next = '0;
          octets_done_next = '0;
        end else if (hv[4]) begin
          phase_next = PH_ERR_ILLEGAL;
        end else begin
          result.valid      = 1'b1;
          result.byte_value = {high_nibble, hv[3:0]};
          result.byte_index = octets_done[3:0];
          octets_done_next  = octets_done + CNT_W'(1);
          phase_next        = PH_AFTER;
        end
      end
      PH_AFTER: begin
        phase_next = PH_START;
        skip       = !is_nul && (char_code == separator_char);
        run_start  = !skip;
      end
      PH_START: begin
        run_start = 1'b1;
      end
      default: begin
        // unused phase codes restart the string
        base_done        = '0;
        high_nibble_next = '0;
        octets_done_next = '0;
        phase_next       = PH_START;
        run_start        = 1'b1;
      end
    endcase

    // start of an octet, or end of string once all octets are in
    if (run_start) begin
      if (base_done >= wanted) begin
        if (is_nul) begin
          result.valid     = 1'b1;
          result.last      = 1'b1;
          result.status    = ST_OK;
          phase_next       = PH_START;
          high_nibble_next = '0;
          octets_done_next = '0;
        end else begin
          phase_next = PH_ERR_LONG;
        end
      end else if (is_nul) begin
        result.valid     = 1'b1;
        result.last      = 1'b1;
        result.status    = ST_SHORT;
        phase_next       = PH_START;
        high_nibble_next = '0;
        octets_done_next = '0;
      end else if (hv[4]) begin
        phase_next = PH_ERR_ILLEGAL;
      end else begin
        high_nibble_next = hv[3:0];
        phase_next       = PH_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      high_nibble <= '0;
      octets_done <= '0;
    end else if (step) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      octets_done <= octets_done_next;
    end
  end

endmodule

// ===== rtl/mac_address_hex_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_hex_parser
// streaming parser for hex mac address strings, one character per item
// ----------------------------------------------------------------------------
// usage
//   char channel: char_valid/char_ready carry one character per item; a zero
//     character ends the string
//   result channel: res_valid/res_ready carry one item per decoded octet
//     (byte_value, byte_index) and one final item per string with last set
//     and status 0 ok, 1 too short, 2 too long, 3 illegal character
//   config port: cfg_we writes cfg_data to register cfg_index
//     (0 octet_count, 1 separator_char); write only while idle
// timing
//   one character accepted every cycle while char_ready is high; an accepted
//   character is loaded into the input register, and its parse step then
//   goes into the result register, which drives res_valid
// reset
//   rst clears both stages and the parse state; octet_count goes to 6 and
//   separator_char to ':'
// stall
//   while res_ready is low a full result register holds; characters that
//   make no result keep flowing, one that makes a result waits in the
//   input register and char_ready drops once that register cannot drain
// ----------------------------------------------------------------------------
module mac_address_hex_parser (
  input  logic       clk,
  input  logic       rst,
  // config port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // character channel
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_code,
  // result channel
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] byte_value,
  output logic [3:0] byte_index,
  output logic [1:0] status,
  output logic       last
);
  import mahp_pkg::*;

  // configuration registers
  logic [CNT_W-1:0] octet_count;
  logic [7:0]       separator_char;

  // input register
  logic             in_full;
  logic [7:0]       in_char;

  // parse step
  mahp_result_t     step_res;
  logic             advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      octet_count    <= CNT_W'(6);
      separator_char <= 8'h3a;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OCTET_COUNT: octet_count    <= cfg_data[CNT_W-1:0];
        REG_SEPARATOR:   separator_char <= cfg_data;
        default:         ;
      endcase
    end
  end

  // an item leaves the input register when it makes no result or when
  // the result register is free or being emptied
  assign advance    = in_full && (!step_res.valid || !res_valid || res_ready);
  assign char_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_ready) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_char <= char_code;
    end
  end

  mahp_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .char_code      (in_char),
    .octet_count    (octet_count),
    .separator_char (separator_char),
    .result         (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && step_res.valid) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      byte_value <= step_res.byte_value;
      byte_index <= step_res.byte_index;
      status     <= step_res.status;
      last       <= step_res.last;
    end
  end

endmodule

// ===== sim/mahp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahp_checker
// watches the character, result and config ports of the mac address parser,
// keeps its own model of the parse state and compares every result item
// ----------------------------------------------------------------------------
module mahp_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       char_valid,
  input  logic       char_ready,
  input  logic [7:0] char_code,
  input  logic       res_valid,
  input  logic       res_ready,
  input  logic [7:0] byte_value,
  input  logic [3:0] byte_index,
  input  logic [1:0] status,
  input  logic       last,
  output int         fail_count,
  output int         pending,
  output int         results_checked
);
  import mahp_pkg::*;

  localparam logic [7:0] NUL_CHAR      = 8'h00;
  localparam logic [4:0] RESET_OCTETS  = 5'd6;
  localparam logic [7:0] RESET_SEP     = ":";

  typedef struct packed {
    logic [7:0] value;
    logic [3:0] index;
    logic [1:0] stat;
    logic       last;
  } parse_out_t;

  parse_out_t         expected_out[$];
  logic [PHASE_W-1:0] phase_r;
  logic [3:0]         hi_nib;
  logic [CNT_W-1:0]   done_r;
  logic [CNT_W-1:0]   cfg_octets;
  logic [7:0]         cfg_sep;
  int                 fails = 0;
  int                 queued = 0;
  int                 checked = 0;

  assign fail_count      = fails;
  assign pending         = queued;
  assign results_checked = checked;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if (lc >= "a" && lc <= "f") return {1'b0, lc[3:0] + 4'd9};
    return 5'h10;
  endfunction

  task automatic finish_string(input logic [1:0] st);
    parse_out_t item;
    item.value = 8'd0;
    item.index = 4'd0;
    item.stat  = st;
    item.last  = 1'b1;
    expected_out.push_back(item);
    phase_r = PH_START;
    hi_nib  = 4'd0;
    done_r  = '0;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [4:0]       d;
    logic [CNT_W-1:0] goal;
    parse_out_t       item;
    d    = nibble_of(c);
    goal = (cfg_octets > MAX_OCTETS) ? CNT_W'(MAX_OCTETS) : cfg_octets;
    case (phase_r)
      PH_ERR_LONG:    if (c == NUL_CHAR) finish_string(ST_LONG);
      PH_ERR_ILLEGAL: if (c == NUL_CHAR) finish_string(ST_ILLEGAL);
      PH_LOW: begin
        if (c == NUL_CHAR) finish_string(ST_SHORT);
        else if (d[4]) phase_r = PH_ERR_ILLEGAL;
        else begin
          item.value = {hi_nib, d[3:0]};
          item.index = done_r[3:0];
          item.stat  = ST_OK;  // octet items carry a zero status
          item.last  = 1'b0;
          expected_out.push_back(item);
          done_r  = done_r + 1'b1;
          phase_r = PH_AFTER;
        end
      end
      default: begin
        // separator wins right after an octet, even when it is a hex digit
        if (phase_r == PH_AFTER && c != NUL_CHAR && c == cfg_sep) phase_r = PH_START;
        else begin
          phase_r = PH_START;
          if (done_r >= goal) begin
            if (c == NUL_CHAR) finish_string(ST_OK);
            else phase_r = PH_ERR_LONG;
          end else if (c == NUL_CHAR) finish_string(ST_SHORT);
          else if (d[4]) phase_r = PH_ERR_ILLEGAL;
          else begin
            hi_nib  = d[3:0];
            phase_r = PH_LOW;
          end
        end
      end
    endcase
  endtask

  task automatic check_result();
    parse_out_t want;
    if (expected_out.size() == 0) begin
      $display("%0t: unexpected result value %0d index %0d status %0d last %0d",
               $time, byte_value, byte_index, status, last);
      fails++;
    end else begin
      want = expected_out.pop_front();
      if (byte_value !== want.value) begin
        $display("%0t: byte_value expected %0d actual %0d", $time, want.value, byte_value);
        fails++;
      end
      if (byte_index !== want.index) begin
        $display("%0t: byte_index expected %0d actual %0d", $time, want.index, byte_index);
        fails++;
      end
      if (status !== want.stat) begin
        $display("%0t: status expected %0d actual %0d", $time, want.stat, status);
        fails++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, last);
        fails++;
      end
      checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_out.delete();
      cfg_octets = RESET_OCTETS;
      cfg_sep    = RESET_SEP;
      phase_r    = PH_START;
      hi_nib     = 4'd0;
      done_r     = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OCTET_COUNT) cfg_octets = cfg_data[CNT_W-1:0];
        else cfg_sep = cfg_data;
      end
      if (char_valid && char_ready) parse_char(char_code);
      if (res_valid && res_ready) check_result();
    end
    queued = expected_out.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives character strings into the mac address parser under changing octet
// counts and separators, with random gaps and result stalls; a checker beside
// the block predicts every octet and status item and counts mismatches
// ----------------------------------------------------------------------------
module testbench;
  import mahp_pkg::*;

  localparam logic [7:0] NUL_CHAR       = 8'h00;
  localparam logic [7:0] CH_ZERO        = "0";
  localparam logic [7:0] CH_UPPER_A     = "A";
  localparam logic [7:0] CH_LOWER_A     = "a";
  localparam int         ITEM_TARGET    = 1700;
  localparam int         QUIET_TAIL     = 1450;  // no idling past this many chars
  localparam int         WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_OCTET_COUNT;
  logic [7:0] cfg_data = 8'd0;
  logic       char_valid = 1'b0;
  logic       char_ready;
  logic [7:0] char_code = 8'd0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic [7:0] byte_value;
  logic [3:0] byte_index;
  logic [1:0] status;
  logic       last;

  int fail_count;
  int pending;
  int results_checked;

  // stimulus bookkeeping
  logic       idle_on = 1'b1;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  int         chars_sent = 0;
  int         strings_sent = 0;
  int         settings_used = 0;
  logic [4:0] cur_octets = 5'd6;
  logic [7:0] cur_sep = ":";
  logic [7:0] text_q[$];

  mac_address_hex_parser dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .byte_value (byte_value),
    .byte_index (byte_index),
    .status     (status),
    .last       (last)
  );

  mahp_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .char_valid      (char_valid),
    .char_ready      (char_ready),
    .char_code       (char_code),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .byte_value      (byte_value),
    .byte_index      (byte_index),
    .status          (status),
    .last            (last),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure: random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      res_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      res_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // watchdog: too long with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one character item; returns at the edge where it was accepted
  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= c;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic end_string();
    send_char(NUL_CHAR);
    strings_sent++;
  endtask

  // drop valid, let every expected result drain, then cover the pipeline
  // for characters that made no result
  task automatic settle();
    char_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] n, input logic [7:0] sep);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_OCTET_COUNT;
    cfg_data  <= {3'b000, n};
    @(posedge clk);
    cfg_index <= REG_SEPARATOR;
    cfg_data  <= sep;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_octets = n;
    cur_sep    = sep;
    settings_used++;
  endtask

  // hex digit for a nibble, random case for letters
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + nib;
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + (nib - 4'd10);
  endfunction

  // fills text_q with one string body, no terminator
  task automatic make_string();
    int kind;
    int k;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      // noise of any non-nul byte
      k = $urandom_range(0, 6);
      repeat (k) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      // well-formed address with random digits and random separators
      for (int i = 0; i < cur_octets; i++) begin
        text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        if (cur_sep != NUL_CHAR && $urandom_range(0, 1)) text_q.push_back(cur_sep);
      end
      if (kind >= 7) begin
        case ($urandom_range(0, 2))
          0: begin
            // cut short anywhere
            if (text_q.size() > 0) begin
              k = $urandom_range(0, text_q.size() - 1);
              while (text_q.size() > k) void'(text_q.pop_back());
            end
          end
          1: begin
            // trailing extra text
            repeat ($urandom_range(1, 3)) begin
              case ($urandom_range(0, 2))
                0: text_q.push_back(cur_sep == NUL_CHAR ? CH_ZERO : cur_sep);
                1: text_q.push_back(hex_char(4'($urandom_range(0, 15))));
                default: text_q.push_back(8'($urandom_range(1, 255)));
              endcase
            end
          end
          default: begin
            // one character replaced by a random byte
            if (text_q.size() > 0) begin
              k = $urandom_range(0, text_q.size() - 1);
              text_q[k] = ($urandom_range(0, 3) == 0 && cur_sep != NUL_CHAR) ?
                          cur_sep : 8'($urandom_range(1, 255));
            end
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, nul in the low digit gives too short
    send_text("fF:0");
    end_string();
    // a hex letter as separator is taken as separator right after an octet
    set_config(5'd1, "a");
    send_text("9Aa");
    end_string();
    // non-hex character in a digit position
    send_text("g");
    end_string();
    // separator register zero: nul right after the octet ends the string
    set_config(5'd1, NUL_CHAR);
    send_text("ab");
    end_string();
    // zero octets: bare nul is ok, anything else is too long
    set_config(5'd0, NUL_CHAR);
    end_string();
    send_char(8'hFF);
    end_string();
    // nul where the next high digit is due
    set_config(5'd2, 8'hFF);
    send_text("12");
    send_char(8'hFF);
    end_string();
    // octet count lowered under a half-parsed string
    send_text("34");
    set_config(5'd1, ":");
    end_string();

    // random phases, each under its own register setting
    while (chars_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       cur_octets = 5'd0;
        1:       cur_octets = 5'd16;
        2:       cur_octets = 5'($urandom_range(1, 3));
        3:       cur_octets = 5'd6;
        default: cur_octets = 5'($urandom_range(0, 16));
      endcase
      case ($urandom_range(0, 4))
        0:       cur_sep = ":";
        1:       cur_sep = "-";
        2:       cur_sep = hex_char(4'($urandom_range(0, 15)));
        3:       cur_sep = $urandom_range(0, 1) ? 8'hFF : 8'h01;
        default: cur_sep = 8'($urandom_range(1, 255));
      endcase
      set_config(cur_octets, cur_sep);
      repeat ($urandom_range(4, 12)) begin
        idle_on <= (chars_sent < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
        make_string();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i]);
        end_string();
      end
      // sometimes leave a string open across the next register change
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) send_char(hex_char(4'($urandom_range(0, 15))));
    end

    // close any open string, then drain
    idle_on <= 1'b0;
    end_string();
    settle();
    repeat (6) @(posedge clk);
    @(negedge clk);
    $display("sent %0d characters in %0d strings under %0d register settings",
             chars_sent, strings_sent, settings_used);
    $display("compared %0d octet and status items against the prediction", results_checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mahp_pkg.sv
rtl/mahp_parser.sv
rtl/mac_address_hex_parser.sv
sim/mahp_checker.sv
sim/testbench.sv
